FILE: rtl/core/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies.
package qrs_pkg;

    // Width of each root field on the output
    localparam int ROOT_WIDTH = 34;

    typedef logic [1:0] count_t;

    localparam count_t CNT_NONE     = 2'd0;
    localparam count_t CNT_ONE      = 2'd1;
    localparam count_t CNT_TWO      = 2'd2;
    localparam count_t CNT_INFINITE = 2'd3;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

FILE: rtl/core/quadratic_root_solver_unit.sv
// Quadratic root solver: one beat per cycle while the output beat is not stalled.
// Stages: products, discriminant, SQW square root cells, numerator setup, NW divider cells, output.
// SQW = ceil((2*COEF_WIDTH+1+2*FRAC_BITS)/2), NW = max(COEF_WIDTH+FRAC_BITS+1, SQW+1)+1.
// The whole pipe advances unless the output beat is stalled; reset clears valid bits only.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [COEF_WIDTH-1:0]          coef_a,
    input  logic [COEF_WIDTH-1:0]          coef_b,
    input  logic [COEF_WIDTH-1:0]          coef_c,
    output logic                           out_valid,
    input  logic                           out_stall,
    output qrs_pkg::count_t                root_count,
    output logic [qrs_pkg::ROOT_WIDTH-1:0] root_first,
    output logic [qrs_pkg::ROOT_WIDTH-1:0] root_second
);
    import qrs_pkg::*;

    localparam int W    = COEF_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = 2*W + 1;
    localparam int SQW  = (DW + 2*F + 1) / 2;
    localparam int NBW  = W + F + 1;
    localparam int DNW  = W + 1;
    localparam int NW   = imax(NBW, SQW + 1) + 1;
    localparam int SSW  = 2 + NBW + DNW;
    localparam int XW   = imax(NW + 1, ROOT_WIDTH) + 1;
    localparam int NST  = SQW + NW + 4;

    logic en;
    logic [NST-1:0] vld_reg;

    assign en       = !(vld_reg[NST-1] && out_stall);
    assign in_stall = !en;

    // valid row, one bit per pipeline stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // stage 1: magnitudes, products, linear/quadratic numerator and divisor
    logic [W-1:0] a_m, b_m, c_m;
    logic [2*W-1:0] b2_reg, ac_reg;
    logic a0_reg, b0_reg, c0_reg, acpos_reg;
    logic signed [NBW-1:0] nb_reg;
    logic signed [DNW-1:0] den_reg;

    always_comb
    begin
        a_m = coef_a[W-1] ? (~coef_a + 1'b1) : coef_a;
        b_m = coef_b[W-1] ? (~coef_b + 1'b1) : coef_b;
        c_m = coef_c[W-1] ? (~coef_c + 1'b1) : coef_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_reg    <= (2*W)'(b_m) * (2*W)'(b_m);
            ac_reg    <= (2*W)'(a_m) * (2*W)'(c_m);
            a0_reg    <= (coef_a == '0);
            b0_reg    <= (coef_b == '0);
            c0_reg    <= (coef_c == '0);
            acpos_reg <= (coef_a[W-1] == coef_c[W-1]) && (coef_c != '0);
            if (coef_a == '0)
            begin
                nb_reg  <= '0 - (NBW'($signed(coef_c)) <<< F);
                den_reg <= DNW'($signed(coef_b));
            end
            else
            begin
                nb_reg  <= '0 - (NBW'($signed(coef_b)) <<< F);
                den_reg <= DNW'($signed(coef_a)) <<< 1;
            end
        end
    end

    // stage 2: discriminant sign, root count, radicand
    logic [2*W+1:0] b2e, ac4, dsum;
    logic dpos, dzero;
    count_t cnt;
    logic [2*SQW-1:0] rad_reg;
    logic [SSW-1:0]   side2_reg;

    always_comb
    begin
        b2e = (2*W+2)'(b2_reg);
        ac4 = {ac_reg, 2'b00};
        if (!acpos_reg)
        begin
            dsum  = b2e + ac4;
            dzero = (dsum == '0);
            dpos  = !dzero;
        end
        else
        begin
            dsum  = b2e - ac4;
            dzero = (b2e == ac4);
            dpos  = (b2e > ac4);
        end
        if (a0_reg && b0_reg && c0_reg)
            cnt = CNT_INFINITE;
        else if (a0_reg)
            cnt = b0_reg ? CNT_NONE : CNT_ONE;
        else if (dzero)
            cnt = CNT_ONE;
        else if (dpos)
            cnt = CNT_TWO;
        else
            cnt = CNT_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!a0_reg && dpos)
                rad_reg <= (2*SQW)'(dsum[DW-1:0]) << (2*F);
            else
                rad_reg <= '0;
            side2_reg <= {cnt, nb_reg, den_reg};
        end
    end

    // square root row
    logic [2*SQW-1:0] s_rad  [SQW+1];
    logic [SQW+1:0]   s_rem  [SQW+1];
    logic [SQW-1:0]   s_root [SQW+1];
    logic [SSW-1:0]   s_side [SQW+1];

    assign s_rad[0]  = rad_reg;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_side[0] = side2_reg;

    for (genvar i = 0; i < SQW; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(.SQW(SQW), .SW(SSW)) u_cell (
            .clk      (clk),
            .en       (en),
            .in_rad   (s_rad[i]),
            .in_rem   (s_rem[i]),
            .in_root  (s_root[i]),
            .in_side  (s_side[i]),
            .out_rad  (s_rad[i+1]),
            .out_rem  (s_rem[i+1]),
            .out_root (s_root[i+1]),
            .out_side (s_side[i+1])
        );
    end

    // numerators -b*one +/- s (-c*one when a is zero), magnitudes and quotient signs
    count_t sq_cnt;
    logic signed [NBW-1:0] sq_nb;
    logic signed [DNW-1:0] sq_den;
    logic signed [NW-1:0]  num1, num2, sroot;
    logic [NW-1:0] n1m_reg, n2m_reg;
    logic [DNW-1:0] dm_reg;
    logic [3:0] side3_reg;

    always_comb
    begin
        {sq_cnt, sq_nb, sq_den} = s_side[SQW];
        sroot = $signed(NW'(s_root[SQW]));
        num1  = NW'(sq_nb) + sroot;
        num2  = NW'(sq_nb) - sroot;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1m_reg   <= num1[NW-1] ? NW'(-num1) : NW'(num1);
            n2m_reg   <= num2[NW-1] ? NW'(-num2) : NW'(num2);
            dm_reg    <= sq_den[DNW-1] ? DNW'(-sq_den) : DNW'(sq_den);
            side3_reg <= {sq_cnt, num1[NW-1] ^ sq_den[DNW-1], num2[NW-1] ^ sq_den[DNW-1]};
        end
    end

    // divider rows, first root carries the count and both signs
    logic [NW-1:0]  d1_nq [NW+1], d2_nq [NW+1];
    logic [DNW-1:0] d1_rem[NW+1], d2_rem[NW+1], d1_den[NW+1], d2_den[NW+1];
    logic [3:0]     d1_side[NW+1];
    logic           d2_side[NW+1];

    assign d1_nq[0]   = n1m_reg;
    assign d2_nq[0]   = n2m_reg;
    assign d1_rem[0]  = '0;
    assign d2_rem[0]  = '0;
    assign d1_den[0]  = dm_reg;
    assign d2_den[0]  = dm_reg;
    assign d1_side[0] = side3_reg;
    assign d2_side[0] = side3_reg[0];

    for (genvar i = 0; i < NW; i++)
    begin : g_div
        qrs_div_cell #(.NW(NW), .DV(DNW), .SW(4)) u_d1 (
            .clk      (clk),
            .en       (en),
            .in_nq    (d1_nq[i]),
            .in_rem   (d1_rem[i]),
            .in_den   (d1_den[i]),
            .in_side  (d1_side[i]),
            .out_nq   (d1_nq[i+1]),
            .out_rem  (d1_rem[i+1]),
            .out_den  (d1_den[i+1]),
            .out_side (d1_side[i+1])
        );
        qrs_div_cell #(.NW(NW), .DV(DNW), .SW(1)) u_d2 (
            .clk      (clk),
            .en       (en),
            .in_nq    (d2_nq[i]),
            .in_rem   (d2_rem[i]),
            .in_den   (d2_den[i]),
            .in_side  (d2_side[i]),
            .out_nq   (d2_nq[i+1]),
            .out_rem  (d2_rem[i+1]),
            .out_den  (d2_den[i+1]),
            .out_side (d2_side[i+1])
        );
    end

    // sign fix, saturation, masking by count
    localparam logic signed [XW-1:0] RMAX = XW'((64'(1) << (ROOT_WIDTH - 1)) - 64'(1));
    localparam logic signed [XW-1:0] RMIN = -RMAX - XW'(1);

    count_t fin_cnt;
    logic fin_s1;
    logic signed [XW-1:0] q1, q2;
    logic [ROOT_WIDTH-1:0] r1, r2;
    count_t cnt_reg;
    logic [ROOT_WIDTH-1:0] r1_reg, r2_reg;

    always_comb
    begin
        {fin_cnt, fin_s1} = d1_side[NW][3:1];
        q1 = $signed(XW'(d1_nq[NW]));
        q2 = $signed(XW'(d2_nq[NW]));
        if (fin_s1)
            q1 = -q1;
        if (d2_side[NW])
            q2 = -q2;
        if (q1 > RMAX)
            r1 = RMAX[ROOT_WIDTH-1:0];
        else if (q1 < RMIN)
            r1 = RMIN[ROOT_WIDTH-1:0];
        else
            r1 = q1[ROOT_WIDTH-1:0];
        if (q2 > RMAX)
            r2 = RMAX[ROOT_WIDTH-1:0];
        else if (q2 < RMIN)
            r2 = RMIN[ROOT_WIDTH-1:0];
        else
            r2 = q2[ROOT_WIDTH-1:0];
        if (fin_cnt != CNT_ONE && fin_cnt != CNT_TWO)
            r1 = '0;
        if (fin_cnt != CNT_TWO)
            r2 = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt_reg <= fin_cnt;
            r1_reg  <= r1;
            r2_reg  <= r2;
        end
    end

    assign out_valid   = vld_reg[NST-1];
    assign root_count  = cnt_reg;
    assign root_first  = r1_reg;
    assign root_second = r2_reg;
endmodule

FILE: rtl/core/qrs_sqrt_cell.sv
// One restoring square root step: brings down two radicand bits, decides one root bit.
// No package dependencies; used by quadratic_root_solver_unit.
module qrs_sqrt_cell #(
    parameter int SQW = 33,
    parameter int SW  = 8
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [2*SQW-1:0]     in_rad,
    input  logic [SQW+1:0]       in_rem,
    input  logic [SQW-1:0]       in_root,
    input  logic [SW-1:0]        in_side,
    output logic [2*SQW-1:0]     out_rad,
    output logic [SQW+1:0]       out_rem,
    output logic [SQW-1:0]       out_root,
    output logic [SW-1:0]        out_side
);
    logic [2*SQW-1:0] rad_reg;
    logic [SQW+1:0]   rem_reg, rem_next, shifted, trial;
    logic [SQW-1:0]   root_reg, root_next;
    logic [SW-1:0]    side_reg;

    // trial subtract of (root*4 + 1)
    always_comb
    begin
        shifted = {in_rem[SQW-1:0], in_rad[2*SQW-1 -: 2]};
        trial   = {in_root, 2'b01};
        if (shifted >= trial)
        begin
            rem_next  = shifted - trial;
            root_next = {in_root[SQW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = shifted;
            root_next = {in_root[SQW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {in_rad[2*SQW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_rad  = rad_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_side = side_reg;
endmodule

FILE: rtl/core/qrs_div_cell.sv
// One restoring division step on magnitudes: one quotient bit per cell.
// No package dependencies; used by quadratic_root_solver_unit.
module qrs_div_cell #(
    parameter int NW = 36,
    parameter int DV = 17,
    parameter int SW = 3
) (
    input  logic            clk,
    input  logic            en,
    input  logic [NW-1:0]   in_nq,
    input  logic [DV-1:0]   in_rem,
    input  logic [DV-1:0]   in_den,
    input  logic [SW-1:0]   in_side,
    output logic [NW-1:0]   out_nq,
    output logic [DV-1:0]   out_rem,
    output logic [DV-1:0]   out_den,
    output logic [SW-1:0]   out_side
);
    logic [NW-1:0] nq_reg;
    logic [DV-1:0] rem_reg, den_reg;
    logic [SW-1:0] side_reg;
    logic [DV:0]   part, diff;
    logic          qbit;

    // shift in the next numerator bit and try the divisor
    always_comb
    begin
        part = {in_rem, in_nq[NW-1]};
        diff = part - {1'b0, in_den};
        qbit = (part >= {1'b0, in_den});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg   <= {in_nq[NW-2:0], qbit};
            rem_reg  <= qbit ? diff[DV-1:0] : part[DV-1:0];
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_nq   = nq_reg;
    assign out_rem  = rem_reg;
    assign out_den  = den_reg;
    assign out_side = side_reg;
endmodule

FILE: rtl/core/qrs_checker.sv
// Port-level checks for quadratic_root_solver_unit, bound to the top level.
// Depends on qrs_pkg and quadratic_root_solver_unit.
module qrs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input qrs_pkg::count_t                root_count,
    input logic [qrs_pkg::ROOT_WIDTH-1:0] root_first,
    input logic [qrs_pkg::ROOT_WIDTH-1:0] root_second
);
    import qrs_pkg::*;

    // stalled output beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root_count)
            && $stable(root_first) && $stable(root_second))
        else $error("stalled output beat changed");

    // input back-pressure only comes from a stalled output
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // second root only present with two roots
    a_r2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_count != CNT_TWO |-> root_second == '0)
        else $error("second root nonzero");

    // no root value with no or infinite roots
    a_r1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_count == CNT_NONE || root_count == CNT_INFINITE)
            |-> root_first == '0)
        else $error("first root nonzero");
endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .root_count  (root_count),
    .root_first  (root_first),
    .root_second (root_second)
);
